>>> src/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg: shared types, constants and decode table for the 8-bit CPU core
// Holds memory sizing, request codes, addressing modes and instruction kinds.
// ----------------------------------------------------------------------------
package ebc_pkg;

   localparam int MEM_ADDR_BITS = 16;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_STEP  = 2'd2;
   localparam logic [1:0] REQ_RESET = 2'd3;

   localparam logic [7:0] FL_C = 8'h01;
   localparam logic [7:0] FL_Z = 8'h02;
   localparam logic [7:0] FL_B = 8'h10;
   localparam logic [7:0] FL_U = 8'h20;
   localparam logic [7:0] FL_V = 8'h40;
   localparam logic [7:0] FL_N = 8'h80;
   localparam logic [7:0] FLAGS_RESET = 8'h24;
   localparam logic [7:0] SP_RESET    = 8'hFF;
   localparam logic [7:0] STACK_PAGE  = 8'h01;

   localparam logic [3:0] AM_NONE = 4'd0;
   localparam logic [3:0] AM_IMM  = 4'd1;
   localparam logic [3:0] AM_ZP   = 4'd2;
   localparam logic [3:0] AM_ZPX  = 4'd3;
   localparam logic [3:0] AM_ZPY  = 4'd4;
   localparam logic [3:0] AM_ABS  = 4'd5;
   localparam logic [3:0] AM_ABSX = 4'd6;
   localparam logic [3:0] AM_ABSY = 4'd7;
   localparam logic [3:0] AM_INDX = 4'd8;
   localparam logic [3:0] AM_INDY = 4'd9;

   localparam logic [4:0] K_LDA = 5'd0;
   localparam logic [4:0] K_LDX = 5'd1;
   localparam logic [4:0] K_LDY = 5'd2;
   localparam logic [4:0] K_STA = 5'd3;
   localparam logic [4:0] K_STX = 5'd4;
   localparam logic [4:0] K_STY = 5'd5;
   localparam logic [4:0] K_AND = 5'd6;
   localparam logic [4:0] K_EOR = 5'd7;
   localparam logic [4:0] K_ORA = 5'd8;
   localparam logic [4:0] K_ADC = 5'd9;
   localparam logic [4:0] K_SBC = 5'd10;
   localparam logic [4:0] K_TAX = 5'd11;
   localparam logic [4:0] K_TAY = 5'd12;
   localparam logic [4:0] K_TSX = 5'd13;
   localparam logic [4:0] K_TXA = 5'd14;
   localparam logic [4:0] K_TXS = 5'd15;
   localparam logic [4:0] K_TYA = 5'd16;
   localparam logic [4:0] K_PHA = 5'd17;
   localparam logic [4:0] K_PHP = 5'd18;
   localparam logic [4:0] K_PLA = 5'd19;
   localparam logic [4:0] K_PLP = 5'd20;
   localparam logic [4:0] K_BAD = 5'd21;

   typedef logic [MEM_ADDR_BITS-1:0] maddr_type;

   typedef struct packed {
      logic [4:0] kind;
      logic [3:0] mode;
      logic [2:0] cyc;
   } dec_type;

   // Memory port request from the sequencer.
   typedef struct packed {
      logic      wr;
      maddr_type addr;
      logic [7:0] wdata;
   } mreq_type;

   function automatic dec_type decode(input logic [7:0] opc);
      dec_type d;
      d = '{kind: K_BAD, mode: AM_NONE, cyc: 3'd0};
      unique case (opc)
         8'hA9: d = '{K_LDA, AM_IMM, 3'd2};
         8'hA5: d = '{K_LDA, AM_ZP, 3'd3};
         8'hAD: d = '{K_LDA, AM_ABS, 3'd4};
         8'h85: d = '{K_STA, AM_ZP, 3'd3};
         8'h8D: d = '{K_STA, AM_ABS, 3'd4};
         8'h95: d = '{K_STA, AM_ZPX, 3'd4};
         8'h9D: d = '{K_STA, AM_ABSX, 3'd5};
         8'h99: d = '{K_STA, AM_ABSY, 3'd5};
         8'h81: d = '{K_STA, AM_INDX, 3'd6};
         8'h91: d = '{K_STA, AM_INDY, 3'd6};
         8'hA2: d = '{K_LDX, AM_IMM, 3'd2};
         8'hA6: d = '{K_LDX, AM_ZP, 3'd3};
         8'hAE: d = '{K_LDX, AM_ABS, 3'd4};
         8'hB6: d = '{K_LDX, AM_ZPY, 3'd4};
         8'hBE: d = '{K_LDX, AM_ABSY, 3'd4};
         8'hA0: d = '{K_LDY, AM_IMM, 3'd2};
         8'hA4: d = '{K_LDY, AM_ZP, 3'd3};
         8'hAC: d = '{K_LDY, AM_ABS, 3'd4};
         8'hB4: d = '{K_LDY, AM_ZPX, 3'd4};
         8'hBC: d = '{K_LDY, AM_ABSX, 3'd4};
         8'h86: d = '{K_STX, AM_ZP, 3'd3};
         8'h8E: d = '{K_STX, AM_ABS, 3'd4};
         8'h96: d = '{K_STX, AM_ZPY, 3'd4};
         8'h84: d = '{K_STY, AM_ZP, 3'd3};
         8'h8C: d = '{K_STY, AM_ABS, 3'd4};
         8'h94: d = '{K_STY, AM_ZPX, 3'd4};
         8'hAA: d = '{K_TAX, AM_NONE, 3'd2};
         8'hA8: d = '{K_TAY, AM_NONE, 3'd2};
         8'hBA: d = '{K_TSX, AM_NONE, 3'd2};
         8'h8A: d = '{K_TXA, AM_NONE, 3'd2};
         8'h9A: d = '{K_TXS, AM_NONE, 3'd2};
         8'h98: d = '{K_TYA, AM_NONE, 3'd2};
         8'h48: d = '{K_PHA, AM_NONE, 3'd3};
         8'h08: d = '{K_PHP, AM_NONE, 3'd3};
         8'h68: d = '{K_PLA, AM_NONE, 3'd4};
         8'h28: d = '{K_PLP, AM_NONE, 3'd4};
         8'h29: d = '{K_AND, AM_IMM, 3'd2};
         8'h25: d = '{K_AND, AM_ZP, 3'd3};
         8'h2D: d = '{K_AND, AM_ABS, 3'd4};
         8'h49: d = '{K_EOR, AM_IMM, 3'd2};
         8'h45: d = '{K_EOR, AM_ZP, 3'd3};
         8'h4D: d = '{K_EOR, AM_ABS, 3'd4};
         8'h09: d = '{K_ORA, AM_IMM, 3'd2};
         8'h05: d = '{K_ORA, AM_ZP, 3'd3};
         8'h0D: d = '{K_ORA, AM_ABS, 3'd4};
         8'h69: d = '{K_ADC, AM_IMM, 3'd2};
         8'h65: d = '{K_ADC, AM_ZP, 3'd3};
         8'h6D: d = '{K_ADC, AM_ABS, 3'd4};
         8'hE9: d = '{K_SBC, AM_IMM, 3'd2};
         8'hE5: d = '{K_SBC, AM_ZP, 3'd3};
         8'hED: d = '{K_SBC, AM_ABS, 3'd4};
         default: d = '{K_BAD, AM_NONE, 3'd0};
      endcase
      return d;
   endfunction

   function automatic maddr_type to_maddr(input logic [15:0] a);
      return a[MEM_ADDR_BITS-1:0];
   endfunction

endpackage

>>> src/ebc_ram.sv
// ----------------------------------------------------------------------------
// ebc_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module ebc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/ebc_alu.sv
// ----------------------------------------------------------------------------
// ebc_alu: operand datapath
// Applies a loaded byte or a register transfer to the registers and computes the new flags.
// ----------------------------------------------------------------------------
module ebc_alu (
   input  logic [4:0] kind,
   input  logic [7:0] operand,
   input  logic [7:0] a,
   input  logic [7:0] x,
   input  logic [7:0] y,
   input  logic [7:0] s,
   input  logic [7:0] p,
   output logic [7:0] a_out,
   output logic [7:0] x_out,
   output logic [7:0] y_out,
   output logic [7:0] s_out,
   output logic [7:0] p_out
);
   import ebc_pkg::*;

   logic [7:0] addend;
   logic [8:0] sum;
   logic [7:0] zn_val;
   logic       zn_upd;
   logic [7:0] p_mid;

   always_comb begin
      addend = (kind == K_SBC) ? ~operand : operand;
      sum    = {1'b0, a} + {1'b0, addend} + {8'd0, p[0]};
      a_out  = a;
      x_out  = x;
      y_out  = y;
      s_out  = s;
      p_mid  = p;
      zn_val = 8'd0;
      zn_upd = 1'b0;
      unique case (kind)
         K_LDA, K_PLA: begin a_out = operand; zn_val = operand; zn_upd = 1'b1; end
         K_LDX: begin x_out = operand; zn_val = operand; zn_upd = 1'b1; end
         K_LDY: begin y_out = operand; zn_val = operand; zn_upd = 1'b1; end
         K_AND: begin a_out = a & operand; zn_val = a_out; zn_upd = 1'b1; end
         K_EOR: begin a_out = a ^ operand; zn_val = a_out; zn_upd = 1'b1; end
         K_ORA: begin a_out = a | operand; zn_val = a_out; zn_upd = 1'b1; end
         K_ADC, K_SBC: begin
            a_out = sum[7:0];
            zn_val = sum[7:0];
            zn_upd = 1'b1;
            p_mid[0] = sum[8];
            p_mid[6] = (~(a[7] ^ addend[7])) & (a[7] ^ sum[7]);
         end
         K_TAX: begin x_out = a; zn_val = a; zn_upd = 1'b1; end
         K_TAY: begin y_out = a; zn_val = a; zn_upd = 1'b1; end
         K_TSX: begin x_out = s; zn_val = s; zn_upd = 1'b1; end
         K_TXA: begin a_out = x; zn_val = x; zn_upd = 1'b1; end
         K_TYA: begin a_out = y; zn_val = y; zn_upd = 1'b1; end
         K_TXS: s_out = x;
         K_PLP: p_mid = (operand & ~(FL_B | FL_U)) | (p & (FL_B | FL_U));
         default: ;
      endcase
      p_out = p_mid;
      if (zn_upd) begin
         p_out[1] = (zn_val == 8'd0);
         p_out[7] = zn_val[7];
      end
   end
endmodule

>>> src/ebc_seq.sv
// ----------------------------------------------------------------------------
// ebc_seq: instruction sequencer
// Walks each request through its memory accesses and owns the registers.
// ----------------------------------------------------------------------------
module ebc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_op,
   input  logic [15:0]          req_addr,
   input  logic [7:0]           req_data,
   output logic                 busy,
   output ebc_pkg::mreq_type    mreq,
   input  logic [7:0]           mem_rdata,
   output logic                 done,
   output logic [7:0]           rd_byte,
   output logic [15:0]          pc,
   output logic [7:0]           a,
   output logic [7:0]           x,
   output logic [7:0]           y,
   output logic [7:0]           s,
   output logic [7:0]           p,
   output logic [2:0]           cyc,
   output logic [7:0]           opc,
   output logic                 bad
);
   import ebc_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RDW   = 4'd1;  // host read data returns
   localparam logic [3:0] ST_OPC   = 4'd2;  // opcode returns
   localparam logic [3:0] ST_B1    = 4'd3;  // first operand byte returns
   localparam logic [3:0] ST_B2    = 4'd4;  // second operand byte returns
   localparam logic [3:0] ST_PLO   = 4'd5;  // pointer low returns
   localparam logic [3:0] ST_PHI   = 4'd6;  // pointer high returns
   localparam logic [3:0] ST_OPND  = 4'd7;  // operand byte returns
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, s_ff, s_in, p_ff, p_in;
   logic [7:0]  opc_ff, opc_in, lo_ff, lo_in, rdb_ff, rdb_in;
   logic [4:0]  kind_ff, kind_in;
   logic [3:0]  mode_ff, mode_in;
   logic [2:0]  cyc_ff, cyc_in;
   logic        bad_ff, bad_in;
   logic [7:0]  alu_opnd;
   logic [4:0]  alu_kind;
   logic        alu_en;
   logic [7:0]  a_alu, x_alu, y_alu, s_alu, p_alu;
   dec_type     dec;
   logic [15:0] ea;
   logic [7:0]  zp;

   assign dec      = decode(mem_rdata);
   assign alu_opnd = mem_rdata;
   // Implied register ops finish in the opcode cycle, so the ALU takes the
   // freshly decoded kind there.
   assign alu_kind = (state_ff == ST_OPC) ? dec.kind : kind_ff;

   ebc_alu u_alu (
      .kind(alu_kind), .operand(alu_opnd),
      .a(a_ff), .x(x_ff), .y(y_ff), .s(s_ff), .p(p_ff),
      .a_out(a_alu), .x_out(x_alu), .y_out(y_alu), .s_out(s_alu), .p_out(p_alu)
   );

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff; s_in = s_ff; p_in = p_ff;
      opc_in = opc_ff; lo_in = lo_ff; rdb_in = rdb_ff;
      kind_in = kind_ff; mode_in = mode_ff; cyc_in = cyc_ff; bad_in = bad_ff;
      mreq = '{wr: 1'b0, addr: to_maddr(pc_ff), wdata: 8'd0};
      alu_en = 1'b0;
      ea = 16'd0;
      zp = 8'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rdb_in = 8'd0; opc_in = 8'd0; cyc_in = 3'd0; bad_in = 1'b0;
               kind_in = K_BAD;
               unique case (req_op)
                  REQ_WRITE: begin
                     mreq = '{wr: 1'b1, addr: to_maddr(req_addr), wdata: req_data};
                     state_in = ST_DONE;
                  end
                  REQ_READ: begin
                     mreq.addr = to_maddr(req_addr);
                     state_in = ST_RDW;
                  end
                  REQ_STEP: state_in = ST_OPC;
                  default: begin
                     pc_in = 16'd0; a_in = 8'd0; x_in = 8'd0; y_in = 8'd0;
                     s_in = SP_RESET; p_in = FLAGS_RESET;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RDW: begin
            rdb_in = mem_rdata;
            state_in = ST_DONE;
         end
         ST_OPC: begin
            opc_in = mem_rdata;
            kind_in = dec.kind; mode_in = dec.mode; cyc_in = dec.cyc;
            bad_in = (dec.kind == K_BAD);
            pc_in = pc_ff + 16'd1;
            state_in = ST_DONE;
            if (dec.mode != AM_NONE) begin
               mreq.addr = to_maddr(pc_ff + 16'd1);
               pc_in = pc_ff + 16'd2;
               state_in = (dec.mode == AM_IMM) ? ST_OPND : ST_B1;
            end else if (dec.kind == K_PHA || dec.kind == K_PHP) begin
               mreq.wr = 1'b1;
               mreq.addr = to_maddr({STACK_PAGE, s_ff});
               mreq.wdata = (dec.kind == K_PHA) ? a_ff : (p_ff | FL_B | FL_U);
               s_in = s_ff - 8'd1;
            end else if (dec.kind == K_PLA || dec.kind == K_PLP) begin
               mreq.addr = to_maddr({STACK_PAGE, s_ff + 8'd1});
               s_in = s_ff + 8'd1;
               state_in = ST_OPND;
            end else if (dec.kind != K_BAD) begin
               alu_en = 1'b1;
            end
         end
         ST_B1: begin
            lo_in = mem_rdata;
            if (mode_ff == AM_ABS || mode_ff == AM_ABSX || mode_ff == AM_ABSY) begin
               mreq.addr = to_maddr(pc_ff);
               pc_in = pc_ff + 16'd1;
               state_in = ST_B2;
            end else if (mode_ff == AM_INDX || mode_ff == AM_INDY) begin
               zp = (mode_ff == AM_INDX) ? mem_rdata + x_ff : mem_rdata;
               lo_in = zp;
               mreq.addr = to_maddr({8'd0, zp});
               state_in = ST_PLO;
            end else begin
               zp = mem_rdata;
               if (mode_ff == AM_ZPX) zp = mem_rdata + x_ff;
               if (mode_ff == AM_ZPY) zp = mem_rdata + y_ff;
               ea = {8'd0, zp};
               state_in = ST_OPND;
            end
         end
         ST_B2: begin
            ea = {mem_rdata, lo_ff};
            if (mode_ff == AM_ABSX) ea = ea + {8'd0, x_ff};
            if (mode_ff == AM_ABSY) ea = ea + {8'd0, y_ff};
            state_in = ST_OPND;
         end
         ST_PLO: begin
            mreq.addr = to_maddr({8'd0, lo_ff + 8'd1});
            lo_in = mem_rdata;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            ea = {mem_rdata, lo_ff};
            if (mode_ff == AM_INDY) ea = ea + {8'd0, y_ff};
            state_in = ST_OPND;
         end
         ST_OPND: begin
            alu_en = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // Effective address reached: store now, or read the operand.
      if (state_in == ST_OPND && (state_ff == ST_B1 || state_ff == ST_B2 ||
                                  state_ff == ST_PHI)) begin
         mreq.addr = to_maddr(ea);
         if (kind_ff == K_STA || kind_ff == K_STX || kind_ff == K_STY) begin
            mreq.wr = 1'b1;
            mreq.wdata = (kind_ff == K_STA) ? a_ff : (kind_ff == K_STX) ? x_ff : y_ff;
            state_in = ST_DONE;
         end
      end
      if (alu_en) begin
         a_in = a_alu; x_in = x_alu; y_in = y_alu; s_in = s_alu; p_in = p_alu;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= 16'd0; a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0;
         s_ff <= SP_RESET; p_ff <= FLAGS_RESET;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; s_ff <= s_in; p_ff <= p_in;
      end
      opc_ff <= opc_in; lo_ff <= lo_in; rdb_ff <= rdb_in;
      kind_ff <= kind_in; mode_ff <= mode_in; cyc_ff <= cyc_in; bad_ff <= bad_in;
   end

   assign busy    = (state_ff != ST_IDLE);
   assign done    = (state_ff == ST_DONE);
   assign rd_byte = rdb_ff;
   assign pc = pc_ff; assign a = a_ff; assign x = x_ff; assign y = y_ff;
   assign s = s_ff; assign p = p_ff;
   assign cyc = cyc_ff; assign opc = opc_ff; assign bad = bad_ff;
endmodule

>>> src/eight_bit_cpu_load_store_alu_core.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_load_store_alu_core: 6502 subset core with internal memory
// Runs load, store, transfer, stack and logic/arithmetic instructions.
// ----------------------------------------------------------------------------
// Usage. A request beat is taken on a rising edge with start high and busy
// low; req_op selects a memory write, a memory read, one instruction step or
// a register reset. Every request yields exactly one response beat: rsp_valid
// is high for one cycle with the registers after the operation on the rsp_
// ports. The receiver cannot stall; the response is simply presented.
// The time from acceptance to the response depends on the request and, for a
// step, on the addressing mode, as every access uses the single memory port.
// The next request can be taken the cycle after the response. All state lives
// in one synchronous byte memory and the register file of the sequencer; reset
// brings the registers to their power-on values and leaves memory untouched
// (memory content is undefined until written). There is no clearing pass.
// ----------------------------------------------------------------------------
module eight_bit_cpu_load_store_alu_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic [15:0] rsp_prog_counter,
   output logic [7:0]  rsp_accum,
   output logic [7:0]  rsp_index_x,
   output logic [7:0]  rsp_index_y,
   output logic [7:0]  rsp_stack_ptr,
   output logic [7:0]  rsp_status_flags,
   output logic [2:0]  rsp_cycle_count,
   output logic [7:0]  rsp_opcode_seen,
   output logic        rsp_unknown_opcode
);
   import ebc_pkg::*;

   mreq_type   mreq;
   logic [7:0] mem_rdata;

   // Single memory port shared by host accesses and instruction steps.
   ebc_ram #(.WIDTH(8), .DEPTH(1 << MEM_ADDR_BITS)) u_mem (
      .clock(clock), .wr_en(mreq.wr), .addr(mreq.addr),
      .wdata(mreq.wdata), .rdata(mem_rdata)
   );

   ebc_seq u_seq (
      .clock(clock), .reset(reset), .start(start),
      .req_op(req_op), .req_addr(req_addr), .req_data(req_data),
      .busy(busy), .mreq(mreq), .mem_rdata(mem_rdata),
      .done(rsp_valid), .rd_byte(rsp_read_data), .pc(rsp_prog_counter),
      .a(rsp_accum), .x(rsp_index_x), .y(rsp_index_y), .s(rsp_stack_ptr),
      .p(rsp_status_flags), .cyc(rsp_cycle_count), .opc(rsp_opcode_seen),
      .bad(rsp_unknown_opcode)
   );

   // A response never appears while the core is idle.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response without a request in flight");

   // The unused flag bit always reads one.
   a_unused_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_flags[5]) else $error("unused flag cleared");

   // An unknown opcode reports a zero rsp_cycle_count.
   a_bad_cycles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unknown_opcode) |-> (rsp_cycle_count == 3'd0))
      else $error("unknown opcode with nonzero cycles");
endmodule
